/* hdl/ptre_pkg.sv */
// Shared types, constants and small lookup functions of the planar tile row encoder.
// No dependencies; every other file of the block imports this package.

package ptre_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int MAX_ROWS          = 1024;
    localparam int MAX_BLOCK_COLUMNS = 128;

    localparam int PIX_W      = 8;
    localparam int NUM_PIX    = 8;
    localparam int PLANES_W   = PIX_W * NUM_PIX;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 10;
    localparam int OY_W       = 3;
    localparam int BY_W       = ROW_W - OY_W;
    localparam int BLK_W      = 5;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int TILE_W     = 15;
    localparam int FULL_W     = 32;
    localparam int OUT_ADDR_W = 16;
    localparam int QUEUE_DEPTH = 4;

    // Stream payload layout.
    localparam int COL_LSB    = PLANES_W;
    localparam int ROW_LSB    = COL_LSB + COL_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_DEPTH_MODE   = 3'd0;
    localparam logic [2:0] REG_COLOR_OFFSET = 3'd1;
    localparam logic [2:0] REG_TILE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_TILE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_TILES_ACROSS = 3'd4;

    localparam logic [1:0] DEPTH_2BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;

    typedef struct packed {
        logic [1:0]       depth_mode;
        logic [PIX_W-1:0] color_offset;
        logic [BLK_W-1:0] tile_width_blocks;
        logic [BLK_W-1:0] tile_height_blocks;
        logic [7:0]       tiles_across;
    } t_cfg;

    typedef struct packed {
        logic [FULL_W-1:0]   base;
        logic [PLANES_W-1:0] planes;
    } t_entry;

    // Zero counts as one block, anything above sixteen as sixteen.
    function automatic logic [BLK_W-1:0] clamp_blocks(input logic [BLK_W-1:0] v);
        logic [BLK_W-1:0] res;
        if (v == '0) begin
            res = BLK_W'(1);
        end else if (v > BLK_W'(16)) begin
            res = BLK_W'(16);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // floor(65536 / d) for divisors one to sixteen.
    function automatic logic [RECIP_W-1:0] recip_q16(input logic [BLK_W-1:0] d);
        logic [RECIP_W-1:0] res;
        case (d)
            5'd1:    res = 17'd65536;
            5'd2:    res = 17'd32768;
            5'd3:    res = 17'd21845;
            5'd4:    res = 17'd16384;
            5'd5:    res = 17'd13107;
            5'd6:    res = 17'd10922;
            5'd7:    res = 17'd9362;
            5'd8:    res = 17'd8192;
            5'd9:    res = 17'd7281;
            5'd10:   res = 17'd6553;
            5'd11:   res = 17'd5957;
            5'd12:   res = 17'd5461;
            5'd13:   res = 17'd5041;
            5'd14:   res = 17'd4681;
            5'd15:   res = 17'd4369;
            default: res = 17'd4096;
        endcase
        return res;
    endfunction

    // Grouped tiles in one 16-block row: 16 / tile width.
    function automatic logic [BLK_W-1:0] tiles_per_row(input logic [BLK_W-1:0] tw);
        logic [BLK_W-1:0] res;
        case (tw)
            5'd1:    res = 5'd16;
            5'd2:    res = 5'd8;
            5'd3:    res = 5'd5;
            5'd4:    res = 5'd4;
            5'd5:    res = 5'd3;
            5'd6:    res = 5'd2;
            5'd7:    res = 5'd2;
            5'd8:    res = 5'd2;
            default: res = 5'd1;
        endcase
        return res;
    endfunction

    // log2 of the bytes in one 8x8 block: 16, 32 or 64.
    function automatic logic [2:0] plane_shift(input logic [1:0] mode);
        logic [2:0] res;
        case (mode)
            DEPTH_2BPP: res = 3'd4;
            DEPTH_4BPP: res = 3'd5;
            default:    res = 3'd6;
        endcase
        return res;
    endfunction

    // Index of the final beat of an item: planes minus one.
    function automatic logic [2:0] last_beat(input logic [1:0] mode);
        logic [2:0] res;
        case (mode)
            DEPTH_2BPP: res = 3'd1;
            DEPTH_4BPP: res = 3'd3;
            default:    res = 3'd7;
        endcase
        return res;
    endfunction

endpackage

/* hdl/ptre_div.sv */
// Three-stage divider by a small divisor (1 to 16) using a stored reciprocal.
// Depends on ptre_pkg; instantiated by ptre_front.

module ptre_div import ptre_pkg::*; #(
    parameter int XW = 7
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [XW-1:0]      i_x,
    input  logic [BLK_W-1:0]   i_d,
    input  logic [RECIP_W-1:0] i_recip,
    output logic [XW-1:0]      o_q,
    output logic [BLK_W-1:0]   o_r
);

    localparam int PW  = XW + RECIP_W;
    localparam int PW2 = XW + BLK_W;

    logic [PW-1:0]  prod;
    logic [XW-1:0]  diff;
    logic [XW-1:0]  r_x1;
    logic [XW-1:0]  r_q1;
    logic [XW-1:0]  r_x2;
    logic [XW-1:0]  r_q2;
    logic [XW-1:0]  r_p2;
    logic [XW-1:0]  r_q3;
    logic [BLK_W-1:0] r_r3;

    // The estimate is the true quotient or one below it.
    assign prod = PW'(i_x) * PW'(i_recip);
    assign diff = r_x2 - r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= i_x;
            r_q1 <= XW'(prod >> RECIP_SHIFT);
            r_x2 <= r_x1;
            r_q2 <= r_q1;
            r_p2 <= XW'(PW2'(r_q1) * PW2'(i_d));
            if (PW2'(diff) >= PW2'(i_d)) begin
                r_q3 <= r_q2 + XW'(1);
                r_r3 <= BLK_W'(PW2'(diff) - PW2'(i_d));
            end else begin
                r_q3 <= r_q2;
                r_r3 <= BLK_W'(diff);
            end
        end
    end

    assign o_q = r_q3;
    assign o_r = r_r3;

endmodule

/* hdl/ptre_front.sv */
// Front part: takes pixel rows, transposes them into bitplanes and works out the
// base byte address in a ten-stage pipeline. Depends on ptre_pkg and ptre_div.

module ptre_front import ptre_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    localparam int LAT  = 10;
    localparam int AX_W = 2 * BLK_W;
    localparam int AY_W = TILE_W + BLK_W;

    typedef struct packed {
        logic [PLANES_W-1:0] planes;
        logic [OY_W-1:0]     oy;
        logic [BLK_W-1:0]    sub_x;
        logic [BLK_W-1:0]    sub_y;
    } t_side;

    logic [LAT:1]        r_v;
    logic                en;
    logic [BLK_W-1:0]    tw;
    logic [BLK_W-1:0]    th;
    logic [BLK_W-1:0]    per_row;
    logic [2:0]          lpx;
    logic [PLANES_W-1:0] n_planes;
    logic [COL_W-1:0]    col_in;
    logic [ROW_W-1:0]    row_in;

    t_side               r_side [1:9];
    logic [COL_W-1:0]    r_col;
    logic [BY_W-1:0]     r_by;
    logic [TILE_W-1:0]   r_tile;
    logic [AX_W-1:0]     r_ax;
    logic [AY_W-1:0]     r_ay;
    logic [FULL_W-1:0]   r_base;
    logic [PLANES_W-1:0] r_planes;

    logic [COL_W-1:0]    div_a_q;
    logic [BLK_W-1:0]    div_a_r;
    logic [BY_W-1:0]     div_b_q;
    logic [BLK_W-1:0]    div_b_r;
    logic [TILE_W-1:0]   div_c_q;
    logic [BLK_W-1:0]    div_c_r;
    logic [FULL_W-1:0]   hi;
    logic [FULL_W-1:0]   n_base;

    assign tw      = clamp_blocks(i_cfg.tile_width_blocks);
    assign th      = clamp_blocks(i_cfg.tile_height_blocks);
    assign per_row = tiles_per_row(tw);
    assign lpx     = plane_shift(i_cfg.depth_mode);

    // The whole pipeline moves together; it holds only when a finished item
    // cannot enter the queue.
    assign en      = !(r_v[LAT] && i_full);
    assign o_ready = en;
    assign o_push  = r_v[LAT] && !i_full;

    assign col_in = COL_W'(32'(i_data[COL_LSB +: COL_W]) % MAX_BLOCK_COLUMNS);
    assign row_in = ROW_W'(32'(i_data[ROW_LSB +: ROW_W]) % MAX_ROWS);

    always_comb begin
        logic [PIX_W-1:0] c;
        n_planes = '0;
        for (int b = 0; b < NUM_PIX; b++) begin
            c = i_data[b*PIX_W +: PIX_W] + i_cfg.color_offset;
            for (int p = 0; p < PIX_W; p++) begin
                n_planes[p*PIX_W + (NUM_PIX - 1 - b)] = c[p];
            end
        end
    end

    ptre_div #(.XW(COL_W)) u_div_col (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_col),
        .i_d     (tw),
        .i_recip (recip_q16(tw)),
        .o_q     (div_a_q),
        .o_r     (div_a_r)
    );

    ptre_div #(.XW(BY_W)) u_div_row (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_by),
        .i_d     (th),
        .i_recip (recip_q16(th)),
        .o_q     (div_b_q),
        .o_r     (div_b_r)
    );

    ptre_div #(.XW(TILE_W)) u_div_tile (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_tile),
        .i_d     (per_row),
        .i_recip (recip_q16(per_row)),
        .o_q     (div_c_q),
        .o_r     (div_c_r)
    );

    always_comb begin
        hi = ((FULL_W'(r_ay) + FULL_W'(r_side[9].sub_y)) << 4)
           + FULL_W'(r_ax) + FULL_W'(r_side[9].sub_x);
        n_base = (hi << lpx) + FULL_W'({r_side[9].oy, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= '{planes: n_planes, oy: row_in[OY_W-1:0], sub_x: '0, sub_y: '0};
            r_col     <= col_in;
            r_by      <= row_in[ROW_W-1:OY_W];
            for (int s = 2; s <= 9; s++) begin
                if (s != 5) begin
                    r_side[s] <= r_side[s-1];
                end
            end
            // Stage five picks up the remainders of the column and row dividers.
            r_side[5] <= '{planes: r_side[4].planes, oy: r_side[4].oy,
                           sub_x: div_a_r, sub_y: div_b_r};
            r_tile   <= TILE_W'(div_a_q)
                      + TILE_W'(div_b_q) * TILE_W'(i_cfg.tiles_across);
            r_ax     <= AX_W'(div_c_r) * AX_W'(tw);
            r_ay     <= AY_W'(div_c_q) * AY_W'(th);
            r_base   <= n_base;
            r_planes <= r_side[9].planes;
        end
    end

    assign o_entry = '{base: r_base, planes: r_planes};

endmodule

/* hdl/ptre_queue.sv */
// Four-entry queue of encoded rows between the front and back parts.
// Depends on ptre_pkg.

module ptre_queue import ptre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full  = r_count == (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("row pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("row popped from an empty queue");

endmodule

/* hdl/ptre_back.sv */
// Back part: walks the planes of the queue head row and drives one address/byte
// beat per cycle when i_ready allows, via an output register. Depends on ptre_pkg.

module ptre_back import ptre_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_depth_mode,
    input  logic                  i_empty,
    input  t_entry                i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_last
);

    localparam logic [FULL_W-1:0] AMASK = (FULL_W'(1) << ADDR_BITS) - FULL_W'(1);

    logic                  r_valid;
    logic [2:0]            r_k;
    logic [OUT_ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]      r_byte;
    logic                  r_ovf;
    logic                  r_last;

    logic                  load;
    logic                  emit;
    logic                  last_k;
    logic [FULL_W-1:0]     addr;

    assign load   = !r_valid || i_ready;
    assign emit   = load && !i_empty;
    assign last_k = r_k == last_beat(i_depth_mode);
    assign o_pop  = emit && last_k;

    // Planes go in pairs: 0 and 1 at +0/+1, 2 and 3 at +16/+17, and so on.
    assign addr = i_head.base + FULL_W'({r_k[2:1], 3'b000, r_k[0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (emit) begin
                r_k <= last_k ? 3'd0 : r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_addr <= OUT_ADDR_W'(addr & AMASK);
            r_byte <= i_head.planes[{r_k, 3'b000} +: PIX_W];
            r_ovf  <= (addr & ~AMASK) != '0;
            r_last <= last_k;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {(OUT_DATA_W - OUT_ADDR_W - PIX_W - 1)'(0), r_ovf, r_byte, r_addr};
    assign o_last  = r_last;

    a_head_held_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 3'd0) |-> !i_empty)
        else $error("queue head left before all its planes were sent");

    a_pop_on_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("queue popped on a beat that is not the last of its row");

endmodule

/* hdl/planar_tile_row_encoder_unit.sv */
// Top level of the planar tile row encoder: configuration registers, front part,
// queue and back part. Depends on ptre_pkg, ptre_front, ptre_queue and ptre_back.
//
// Usage: each beat on the s_axis side carries one pixel row of an 8-pixel block
// (eight palette indices, block column, pixel row). The colour offset is added,
// the row is split into bitplane bytes and each byte leaves on the m_axis side
// with its tile-buffer address, an overflow flag and tlast on the row's final byte.
// A row gives 2, 4 or 8 beats for 2, 4 or 8 bits per pixel.
// Path: a row passes the ten address pipeline stages, the queue write and the
// output register before its first beat appears.
// Throughput: while the receiver is ready, the output register sends one byte per
// cycle; the address pipeline takes a row every cycle unless held by a full queue.
// When the receiver stalls, the output register holds, the four-row queue fills,
// the address pipeline halts and s_axis_tready goes low.
// Reset loads the register defaults (4bpp, offset 0, 1x1 tiles, 16 across) and
// empties the pipeline and queue. The user must write registers over the APB port
// only while no row is in flight; the block itself does not enforce this.

module planar_tile_row_encoder_unit import ptre_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_0..pixel_7 [63:0], block_column [70:64], pixel_row [80:71], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // byte_address [15:0], byte_value [23:16], address_overflow [24], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_index;
    logic       cfg_write;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_entry     front_entry;
    t_entry     head;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode         <= DEPTH_4BPP;
            r_cfg.color_offset       <= '0;
            r_cfg.tile_width_blocks  <= BLK_W'(1);
            r_cfg.tile_height_blocks <= BLK_W'(1);
            r_cfg.tiles_across       <= 8'd16;
        end else if (cfg_write) begin
            case (reg_index)
                REG_DEPTH_MODE:   r_cfg.depth_mode         <= pwdata[1:0];
                REG_COLOR_OFFSET: r_cfg.color_offset       <= pwdata[PIX_W-1:0];
                REG_TILE_WIDTH:   r_cfg.tile_width_blocks  <= pwdata[BLK_W-1:0];
                REG_TILE_HEIGHT:  r_cfg.tile_height_blocks <= pwdata[BLK_W-1:0];
                REG_TILES_ACROSS: r_cfg.tiles_across       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_DEPTH_MODE:   prdata = CFG_DATA_W'(r_cfg.depth_mode);
            REG_COLOR_OFFSET: prdata = CFG_DATA_W'(r_cfg.color_offset);
            REG_TILE_WIDTH:   prdata = CFG_DATA_W'(r_cfg.tile_width_blocks);
            REG_TILE_HEIGHT:  prdata = CFG_DATA_W'(r_cfg.tile_height_blocks);
            REG_TILES_ACROSS: prdata = CFG_DATA_W'(r_cfg.tiles_across);
            default:          prdata = '0;
        endcase
    end

    ptre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    ptre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ptre_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_depth_mode (r_cfg.depth_mode),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule
